// ===== sv/rmt_pkg.sv =====
package rmt_pkg;

	// position and element widths
	localparam int POS_W = 10;
	localparam int VAL_W = 32;
	localparam int DEFAULT_MAX_ELEMENTS = 1024;
	localparam int RESET_LAST = 1023;
	localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;

	// request codes
	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_ADD   = 2'd1,
		REQ_QUERY = 2'd2
	} rmt_req_t;

	// controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_VISIT,
		ST_QACC,
		ST_LEAFADD,
		ST_RETURN,
		ST_REF_A,
		ST_REF_B,
		ST_REF_C,
		ST_DONE
	} rmt_state_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic capture;
		logic start_walk;
		logic descend_left;
		logic go_right;
		logic pop;
		logic rd_cur;
		logic rd_left;
		logic rd_right;
		logic wr_load;
		logic wr_add;
		logic wr_min;
		logic hold_left;
		logic acc_min;
	} rmt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] kind;
		logic       miss;
		logic       prune;
		logic       covered;
		logic       leaf;
		logic       empty;
		logic       top_side;
		logic       clear_last;
	} rmt_stat_t;

endpackage

// ===== sv/rmt_datapath.sv =====
module rmt_datapath #(
	parameter int MAX_ELEMENTS = rmt_pkg::DEFAULT_MAX_ELEMENTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rmt_pkg::rmt_cmd_t                   cmd,
	output rmt_pkg::rmt_stat_t                  stat,
	input  logic [1:0]                          req_type,
	input  logic [rmt_pkg::POS_W-1:0]           range_low,
	input  logic [rmt_pkg::POS_W-1:0]           range_high,
	input  logic signed [rmt_pkg::VAL_W-1:0]    operand_value,
	input  logic                                cfg_write,
	input  logic [rmt_pkg::POS_W-1:0]           cfg_data,
	output logic signed [rmt_pkg::VAL_W-1:0]    min_value,
	output logic                                no_overlap
);

	localparam int POS_W = rmt_pkg::POS_W;
	localparam int VAL_W = rmt_pkg::VAL_W;
	localparam int ADDR_W = $clog2(2 * MAX_ELEMENTS);
	localparam int DEPTH = ADDR_W;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SP_W = $clog2(DEPTH + 1);
	localparam int LAST_MAX = MAX_ELEMENTS - 1;
	localparam int RST_LAST = (rmt_pkg::RESET_LAST > LAST_MAX) ? LAST_MAX : rmt_pkg::RESET_LAST;

	// request and configuration registers
	logic [1:0]              kind_q;
	logic [POS_W-1:0]        lo_q, hi_q, last_q;
	logic signed [VAL_W-1:0] val_q, acc_q, tmp_q, rdata_q;

	// walk position and return stack
	logic [POS_W-1:0]  cur_s_q, cur_e_q;
	logic [ADDR_W-1:0] cur_i_q;
	logic [POS_W-1:0]  stk_s_q [DEPTH];
	logic [POS_W-1:0]  stk_e_q [DEPTH];
	logic [ADDR_W-1:0] stk_i_q [DEPTH];
	logic              stk_side_q [DEPTH];
	logic [SP_W-1:0]   sp_q;
	logic [ADDR_W-1:0] clr_q;

	logic signed [VAL_W-1:0] mem [2**ADDR_W];

	logic [SP_W-1:0]   top_sp;
	logic [IDX_W-1:0]  top_idx, push_idx;
	logic [POS_W-1:0]  cur_mid, top_mid, top_s, top_e;
	logic [ADDR_W-1:0] top_i, left_i, right_i, rd_addr;
	logic [POS_W:0]    cur_sum, top_sum;
	logic signed [VAL_W:0]   sum_w;
	logic signed [VAL_W-1:0] sat_sum, wdata;
	logic              miss_rng, miss_load;

	assign top_sp   = sp_q - SP_W'(1);
	assign top_idx  = top_sp[IDX_W-1:0];
	assign push_idx = sp_q[IDX_W-1:0];
	assign top_s    = stk_s_q[top_idx];
	assign top_e    = stk_e_q[top_idx];
	assign top_i    = stk_i_q[top_idx];
	assign cur_sum  = {1'b0, cur_s_q} + {1'b0, cur_e_q};
	assign cur_mid  = cur_sum[POS_W:1];
	assign top_sum  = {1'b0, top_s} + {1'b0, top_e};
	assign top_mid  = top_sum[POS_W:1];
	assign left_i   = {cur_i_q[ADDR_W-2:0], 1'b0};
	assign right_i  = {cur_i_q[ADDR_W-2:0], 1'b1};

	assign miss_load = lo_q > last_q;
	assign miss_rng  = (lo_q > hi_q) || (lo_q > last_q);

	// status toward the controller
	always_comb begin
		stat.kind       = kind_q;
		stat.miss       = (kind_q == rmt_pkg::REQ_LOAD) ? miss_load : miss_rng;
		stat.leaf       = cur_s_q == cur_e_q;
		stat.covered    = (cur_s_q >= lo_q) && (cur_e_q <= hi_q);
		stat.empty      = sp_q == '0;
		stat.top_side   = stk_side_q[top_idx];
		stat.clear_last = &clr_q;
		if (kind_q == rmt_pkg::REQ_LOAD)
			stat.prune = (lo_q < cur_s_q) || (lo_q > cur_e_q);
		else
			stat.prune = (lo_q > cur_e_q) || (hi_q < cur_s_q);
	end

	// saturating leaf add
	assign sum_w = {rdata_q[VAL_W-1], rdata_q} + {val_q[VAL_W-1], val_q};
	always_comb begin
		if (sum_w > $signed({1'b0, rmt_pkg::INT_MAX}))
			sat_sum = rmt_pkg::INT_MAX;
		else if (sum_w < $signed({1'b1, rmt_pkg::INT_MIN}))
			sat_sum = rmt_pkg::INT_MIN;
		else
			sat_sum = sum_w[VAL_W-1:0];
	end

	// pick write data and read address
	always_comb begin
		if (cmd.wr_load)
			wdata = val_q;
		else if (cmd.wr_add)
			wdata = sat_sum;
		else
			wdata = (tmp_q < rdata_q) ? tmp_q : rdata_q;
		if (cmd.rd_left)
			rd_addr = left_i;
		else if (cmd.rd_right)
			rd_addr = right_i;
		else
			rd_addr = cur_i_q;
	end

	// fill pointer, walks every node once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clear)
			clr_q <= clr_q + ADDR_W'(1);
	end

	// tree memory; the fill makes a never-written child lose every minimum
	always_ff @(posedge clk) begin
		if (cmd.clear)
			mem[clr_q] <= rmt_pkg::INT_MAX;
		else if (cmd.wr_load || cmd.wr_add || cmd.wr_min)
			mem[cur_i_q] <= wdata;
		if (cmd.rd_cur || cmd.rd_left || cmd.rd_right)
			rdata_q <= mem[rd_addr];
	end

	// configuration register, saturated to the tree size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_q <= POS_W'(RST_LAST);
		else if (cfg_write) begin
			if (int'(cfg_data) > LAST_MAX)
				last_q <= POS_W'(LAST_MAX);
			else
				last_q <= cfg_data;
		end
	end

	// stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sp_q <= '0;
		else if (cmd.start_walk)
			sp_q <= '0;
		else if (cmd.descend_left)
			sp_q <= sp_q + SP_W'(1);
		else if (cmd.pop)
			sp_q <= top_sp;
	end

	// request capture, walk and accumulators
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= req_type;
			lo_q   <= range_low;
			hi_q   <= range_high;
			val_q  <= operand_value;
			acc_q  <= rmt_pkg::INT_MAX;
		end
		if (cmd.start_walk) begin
			cur_s_q <= '0;
			cur_e_q <= last_q;
			cur_i_q <= ADDR_W'(1);
		end else if (cmd.descend_left) begin
			stk_s_q[push_idx]    <= cur_s_q;
			stk_e_q[push_idx]    <= cur_e_q;
			stk_i_q[push_idx]    <= cur_i_q;
			stk_side_q[push_idx] <= 1'b0;
			cur_e_q <= cur_mid;
			cur_i_q <= left_i;
		end else if (cmd.go_right) begin
			stk_side_q[top_idx] <= 1'b1;
			cur_s_q <= top_mid + POS_W'(1);
			cur_e_q <= top_e;
			cur_i_q <= {top_i[ADDR_W-2:0], 1'b1};
		end else if (cmd.pop) begin
			cur_s_q <= top_s;
			cur_e_q <= top_e;
			cur_i_q <= top_i;
		end
		if (cmd.hold_left)
			tmp_q <= rdata_q;
		if (cmd.acc_min && (rdata_q < acc_q))
			acc_q <= rdata_q;
	end

	// result word
	always_comb begin
		min_value  = '0;
		no_overlap = 1'b0;
		case (kind_q)
			rmt_pkg::REQ_LOAD:  no_overlap = miss_load;
			rmt_pkg::REQ_ADD:   no_overlap = miss_rng;
			rmt_pkg::REQ_QUERY: begin
				no_overlap = miss_rng;
				min_value  = acc_q;
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/rmt_ctrl.sv =====
module rmt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output rmt_pkg::rmt_cmd_t  cmd,
	input  rmt_pkg::rmt_stat_t stat
);

	rmt_pkg::rmt_state_t state_q, state_n;
	logic is_load, is_add, is_query;

	assign is_load  = stat.kind == rmt_pkg::REQ_LOAD;
	assign is_add   = stat.kind == rmt_pkg::REQ_ADD;
	assign is_query = stat.kind == rmt_pkg::REQ_QUERY;

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rmt_pkg::ST_CLEAR;
		else
			state_q <= state_n;
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			rmt_pkg::ST_CLEAR:
				if (stat.clear_last) state_n = rmt_pkg::ST_IDLE;
			rmt_pkg::ST_IDLE:
				if (start) state_n = rmt_pkg::ST_CHECK;
			rmt_pkg::ST_CHECK:
				if (!(is_load || is_add || is_query) || stat.miss)
					state_n = rmt_pkg::ST_DONE;
				else
					state_n = rmt_pkg::ST_VISIT;
			rmt_pkg::ST_VISIT:
				if (stat.prune)
					state_n = rmt_pkg::ST_RETURN;
				else if (is_query && stat.covered)
					state_n = rmt_pkg::ST_QACC;
				else if (stat.leaf)
					state_n = is_add ? rmt_pkg::ST_LEAFADD : rmt_pkg::ST_RETURN;
				else
					state_n = rmt_pkg::ST_VISIT;
			rmt_pkg::ST_QACC:    state_n = rmt_pkg::ST_RETURN;
			rmt_pkg::ST_LEAFADD: state_n = rmt_pkg::ST_RETURN;
			rmt_pkg::ST_RETURN:
				if (stat.empty)
					state_n = rmt_pkg::ST_DONE;
				else if (!stat.top_side)
					state_n = rmt_pkg::ST_VISIT;
				else if (!is_query)
					state_n = rmt_pkg::ST_REF_A;
			rmt_pkg::ST_REF_A: state_n = rmt_pkg::ST_REF_B;
			rmt_pkg::ST_REF_B: state_n = rmt_pkg::ST_REF_C;
			rmt_pkg::ST_REF_C: state_n = rmt_pkg::ST_RETURN;
			rmt_pkg::ST_DONE:  state_n = rmt_pkg::ST_IDLE;
			default:           state_n = rmt_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd  = '0;
		busy = state_q != rmt_pkg::ST_IDLE;
		done = state_q == rmt_pkg::ST_DONE;
		case (state_q)
			rmt_pkg::ST_CLEAR: cmd.clear = 1'b1;
			rmt_pkg::ST_IDLE:  cmd.capture = start;
			rmt_pkg::ST_CHECK: cmd.start_walk = 1'b1;
			rmt_pkg::ST_VISIT:
				if (!stat.prune) begin
					if (is_query && stat.covered)
						cmd.rd_cur = 1'b1;
					else if (stat.leaf) begin
						cmd.wr_load = is_load;
						cmd.rd_cur  = is_add;
					end else
						cmd.descend_left = 1'b1;
				end
			rmt_pkg::ST_QACC:    cmd.acc_min = 1'b1;
			rmt_pkg::ST_LEAFADD: cmd.wr_add = 1'b1;
			rmt_pkg::ST_RETURN:
				if (!stat.empty) begin
					cmd.go_right = !stat.top_side;
					cmd.pop      = stat.top_side;
				end
			rmt_pkg::ST_REF_A: cmd.rd_left = 1'b1;
			rmt_pkg::ST_REF_B: begin
				cmd.hold_left = 1'b1;
				cmd.rd_right  = 1'b1;
			end
			rmt_pkg::ST_REF_C: cmd.wr_min = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== sv/range_add_range_min_tree.sv =====
// Minimum tree with range add and range-minimum query. Pulse start while busy is low to
// hand over one request; the result shows on min_value and no_overlap for exactly one cycle
// with done high and must be taken then, since the block cannot be held off. After reset the
// block stays busy while it fills the node memory with the largest value, so a parent
// refreshed during loading takes only its written child. A tree walk through one single-port
// node memory sets the time: each node visited passes through a visit and a return state,
// and on the way back a load or add refreshes each parent by reading the left child, reading
// the right child and writing the smaller value. A covered query node adds an accumulate
// state and an added leaf an add state. The time of a range add grows with the number of
// positions in the range. Each request also passes through capture while idle, a check
// state and a result state. Every position must be loaded before it is added to or queried.
module range_add_range_min_tree #(
	parameter int MAX_ELEMENTS = rmt_pkg::DEFAULT_MAX_ELEMENTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       req_type,
	input  logic [rmt_pkg::POS_W-1:0]        range_low,
	input  logic [rmt_pkg::POS_W-1:0]        range_high,
	input  logic signed [rmt_pkg::VAL_W-1:0] operand_value,
	output logic                             done,
	output logic signed [rmt_pkg::VAL_W-1:0] min_value,
	output logic                             no_overlap,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rmt_pkg::POS_W-1:0]        cfg_data
);

	rmt_pkg::rmt_cmd_t  cmd;
	rmt_pkg::rmt_stat_t stat;

	// always take configuration words
	assign cfg_ready = 1'b1;

	rmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	rmt_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req_type),
		.range_low     (range_low),
		.range_high    (range_high),
		.operand_value (operand_value),
		.cfg_write     (cfg_valid & cfg_ready),
		.cfg_data      (cfg_data),
		.min_value     (min_value),
		.no_overlap    (no_overlap)
	);

endmodule

// ===== test/range_add_range_min_tree_test.sv =====
module range_add_range_min_tree_test;

	localparam int POS_W = rmt_pkg::POS_W;
	localparam int VAL_W = rmt_pkg::VAL_W;
	localparam int TREE_NODES = 2 * rmt_pkg::DEFAULT_MAX_ELEMENTS;
	localparam int MAX_POS = rmt_pkg::DEFAULT_MAX_ELEMENTS - 1;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 100000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic signed [VAL_W-1:0] min_value;
		logic                    no_overlap;
	} answer_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [1:0]              req_type = rmt_pkg::REQ_LOAD;
	logic [POS_W-1:0]        range_low = '0;
	logic [POS_W-1:0]        range_high = '0;
	logic signed [VAL_W-1:0] operand_value = '0;
	logic                    done;
	logic signed [VAL_W-1:0] min_value;
	logic                    no_overlap;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [POS_W-1:0]        cfg_data = '0;

	// shadow tree and register
	logic signed [VAL_W-1:0] shadow_tree [TREE_NODES];
	bit                      shadow_written [TREE_NODES];
	int unsigned             shadow_last = MAX_POS;

	answer_t answer_q [$];
	int      fail_count = 0;
	int      words_sent = 0;
	int      answers_checked = 0;
	int      settings_used = 0;
	int      stall_cycles = 0;
	bit      no_idle = 1'b0;

	range_add_range_min_tree uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .range_low(range_low), .range_high(range_high),
		.operand_value(operand_value), .done(done), .min_value(min_value),
		.no_overlap(no_overlap), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic signed [VAL_W-1:0] node_value(int unsigned i);
		if (i >= TREE_NODES || !shadow_written[i])
			return '0;
		return shadow_tree[i];
	endfunction

	function automatic void node_store(int unsigned i, logic signed [VAL_W-1:0] v);
		if (i < TREE_NODES) begin
			shadow_tree[i] = v;
			shadow_written[i] = 1'b1;
		end
	endfunction

	// rebuild a parent from its written children
	function automatic void node_refresh(int unsigned i);
		bit hl, hr;
		logic signed [VAL_W-1:0] vl, vr;
		hl = (2*i < TREE_NODES) && shadow_written[2*i];
		hr = (2*i+1 < TREE_NODES) && shadow_written[2*i+1];
		vl = node_value(2*i);
		vr = node_value(2*i+1);
		if (hl && hr)
			node_store(i, (vl < vr) ? vl : vr);
		else if (hl)
			node_store(i, vl);
		else if (hr)
			node_store(i, vr);
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_sum(logic signed [VAL_W-1:0] a,
			logic signed [VAL_W-1:0] b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > longint'(rmt_pkg::INT_MAX))
			return rmt_pkg::INT_MAX;
		if (s < longint'(rmt_pkg::INT_MIN))
			return rmt_pkg::INT_MIN;
		return s[VAL_W-1:0];
	endfunction

	function automatic void tree_load(int unsigned s, int unsigned e, int unsigned pos,
			logic signed [VAL_W-1:0] v, int unsigned i);
		int unsigned m;
		if (i >= TREE_NODES)
			return;
		if (s == e) begin
			node_store(i, v);
			return;
		end
		m = (s + e) / 2;
		if (pos <= m)
			tree_load(s, m, pos, v, 2*i);
		else
			tree_load(m + 1, e, pos, v, 2*i + 1);
		node_refresh(i);
	endfunction

	function automatic void tree_add(int unsigned s, int unsigned e, int unsigned lo,
			int unsigned hi, logic signed [VAL_W-1:0] inc, int unsigned i);
		int unsigned m;
		if (lo > e || hi < s || i >= TREE_NODES)
			return;
		if (s == e) begin
			node_store(i, sat_sum(node_value(i), inc));
			return;
		end
		m = (s + e) / 2;
		tree_add(s, m, lo, hi, inc, 2*i);
		tree_add(m + 1, e, lo, hi, inc, 2*i + 1);
		node_refresh(i);
	endfunction

	function automatic logic signed [VAL_W-1:0] tree_min(int unsigned s, int unsigned e,
			int unsigned lo, int unsigned hi, int unsigned i);
		int unsigned m;
		logic signed [VAL_W-1:0] a, b;
		if (lo > e || hi < s)
			return rmt_pkg::INT_MAX;
		if (s >= lo && e <= hi)
			return node_value(i);
		m = (s + e) / 2;
		a = tree_min(s, m, lo, hi, 2*i);
		b = tree_min(m + 1, e, lo, hi, 2*i + 1);
		return (a < b) ? a : b;
	endfunction

	// update the shadow tree and queue the answer of one request
	function automatic void predict_answer(logic [1:0] kind, int unsigned lo, int unsigned hi,
			logic signed [VAL_W-1:0] v);
		answer_t ans;
		bit miss;
		miss = (lo > hi) || (lo > shadow_last);
		ans.min_value = '0;
		ans.no_overlap = 1'b0;
		case (kind)
			rmt_pkg::REQ_LOAD: begin
				if (lo > shadow_last)
					ans.no_overlap = 1'b1;
				else
					tree_load(0, shadow_last, lo, v, 1);
			end
			rmt_pkg::REQ_ADD: begin
				if (miss)
					ans.no_overlap = 1'b1;
				else
					tree_add(0, shadow_last, lo, hi, v, 1);
			end
			rmt_pkg::REQ_QUERY: begin
				if (miss) begin
					ans.no_overlap = 1'b1;
					ans.min_value = rmt_pkg::INT_MAX;
				end else begin
					ans.min_value = tree_min(0, shadow_last, lo, hi, 1);
				end
			end
			default: ;
		endcase
		answer_q.push_back(ans);
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// check each answer against the oldest expectation
	always @(posedge clk) begin
		answer_t exp_ans;
		if (arst_n && done) begin
			if (answer_q.size() == 0) begin
				report_mismatch("answer with nothing expected");
			end else begin
				exp_ans = answer_q.pop_front();
				answers_checked++;
				if (min_value !== exp_ans.min_value)
					report_mismatch($sformatf("min_value %0d, expected %0d",
						min_value, exp_ans.min_value));
				if (no_overlap !== exp_ans.no_overlap)
					report_mismatch($sformatf("no_overlap %b, expected %b",
						no_overlap, exp_ans.no_overlap));
			end
		end
	end

	// watchdog: cycles with no handshake of any kind
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog expired, %0d answers outstanding", answer_q.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// hand over one request word and hold start until it is taken
	task automatic send_word(logic [1:0] kind, int unsigned lo, int unsigned hi,
			logic signed [VAL_W-1:0] v);
		start <= 1'b1;
		req_type <= kind;
		range_low <= lo[POS_W-1:0];
		range_high <= hi[POS_W-1:0];
		operand_value <= v;
		do
			@(posedge clk);
		while (busy);
		predict_answer(kind, lo, hi, v);
		words_sent++;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		while (answer_q.size() != 0 || busy)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write last_position while the block is idle
	task automatic set_last(int unsigned last);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= last[POS_W-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_last = (last > MAX_POS) ? MAX_POS : last;
		settings_used++;
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return rmt_pkg::INT_MAX;
			1: return rmt_pkg::INT_MIN;
			2: return $signed(VAL_W'($urandom_range(0, 20))) - 10;
			default: return $urandom;
		endcase
	endfunction

	// load every position in use so later reads see written nodes
	task automatic load_all;
		for (int unsigned p = 0; p <= shadow_last; p++)
			send_word(rmt_pkg::REQ_LOAD, p, 0, pick_value());
	endtask

	task automatic test_directed;
		set_last(7);
		send_word(rmt_pkg::REQ_LOAD, 0, 0, rmt_pkg::INT_MAX);
		send_word(rmt_pkg::REQ_LOAD, 5, 0, -3);
		// query before the whole tree is loaded only touches written nodes
		send_word(rmt_pkg::REQ_QUERY, 4, 7, 0);
		send_word(rmt_pkg::REQ_LOAD, 1, 0, rmt_pkg::INT_MIN);
		for (int unsigned p = 2; p <= 7; p++)
			send_word(rmt_pkg::REQ_LOAD, p, 1023, p * 11);
		send_word(rmt_pkg::REQ_LOAD, 9, 0, 42);
		send_word(rmt_pkg::REQ_QUERY, 0, 7, 0);
		// saturate at both ends
		send_word(rmt_pkg::REQ_ADD, 0, 0, 1);
		send_word(rmt_pkg::REQ_ADD, 1, 1, -1);
		send_word(rmt_pkg::REQ_QUERY, 0, 1, 0);
		send_word(rmt_pkg::REQ_QUERY, 0, 0, 0);
		send_word(rmt_pkg::REQ_QUERY, 5, 2, 0);
		send_word(rmt_pkg::REQ_ADD, 6, 3, 5);
		send_word(rmt_pkg::REQ_QUERY, 8, 1023, 0);
		send_word(rmt_pkg::REQ_ADD, 8, 9, 5);
		send_word(rmt_pkg::REQ_ADD, 2, 1023, rmt_pkg::INT_MIN);
		send_word(rmt_pkg::REQ_QUERY, 3, 1023, 0);
		send_word(REQ_UNUSED, 1023, 1023, -1);
		send_word(rmt_pkg::REQ_ADD, 0, 7, rmt_pkg::INT_MAX);
		send_word(rmt_pkg::REQ_QUERY, 0, 7, 0);
	endtask

	// well-formed requests with random content, plus some noise
	task automatic test_random(int unsigned last, int count);
		int unsigned lo, hi, span, r;
		logic [1:0] kind;
		set_last(last);
		load_all();
		span = (last < 40) ? last : 40;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				kind = 2'($urandom_range(0, 3));
				lo = $urandom_range(0, MAX_POS);
				hi = $urandom_range(0, MAX_POS);
				// bound the span of noise adds on large trees
				if (kind == rmt_pkg::REQ_ADD && hi > lo + 64)
					hi = lo + 64;
			end else begin
				kind = (r < 35) ? rmt_pkg::REQ_LOAD :
					(r < 65) ? rmt_pkg::REQ_ADD : rmt_pkg::REQ_QUERY;
				lo = $urandom_range(0, last);
				hi = lo + $urandom_range(0, span);
				if ($urandom_range(0, 9) == 0)
					hi = lo + $urandom_range(0, 2 * span + 1);
				if (hi > MAX_POS)
					hi = MAX_POS;
			end
			send_word(kind, lo, hi, pick_value());
		end
	endtask

	task automatic test_full_tree;
		no_idle = 1'b1;
		test_random(MAX_POS, 40);
		// whole-range and last-position queries
		send_word(rmt_pkg::REQ_QUERY, 0, MAX_POS, 0);
		send_word(rmt_pkg::REQ_QUERY, MAX_POS, MAX_POS, 0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(0, 15);
		test_random(1, 15);
		test_random(13, 40);
		test_random($urandom_range(2, 40), 30);
		test_full_tree();
		drain();
		$display("covered %0d request words, %0d answers, %0d settings of last_position",
			words_sent, answers_checked, settings_used);
		$display("loads, range adds, queries, saturation, empty and out-of-range requests");
		if (fail_count == 0 && answer_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d answers missing", fail_count, answer_q.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/rmt_pkg.sv
sv/rmt_datapath.sv
sv/rmt_ctrl.sv
sv/range_add_range_min_tree.sv
test/range_add_range_min_tree_test.sv
